// File: rtl/dsa_pkg.sv
package dsa_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int VIEW_W     = 64;
  localparam int BIND_W     = 16;
  localparam int MAX_W      = 7;
  localparam int SIDX_W     = 7;
  localparam int OUT_SLOT_W = 6;
  localparam int CFG_W      = 16;

  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_REMOVE   = 2'd1;
  localparam logic [1:0] REQ_COMMIT   = 2'd2;

  localparam logic CFG_CHANNEL_BINDING = 1'b0;
  localparam logic CFG_MAX_SLOTS       = 1'b1;

  localparam logic OUT_ANSWER = 1'b0;
  localparam logic OUT_WRITE  = 1'b1;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [VIEW_W-1:0] wr_view;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_addr;
    logic              clr_dirty_all;
    logic [SLOT_W-1:0] probe_addr;
  } slot_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] addr;
    logic              live;
    logic              dirty;
    logic              hit;
    logic              more;
    logic              probe_live;
  } slot_stat_t;

endpackage

// File: rtl/dsa_slot_store.sv
module dsa_slot_store import dsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slot_cmd_t         cmd_i,
  input  logic [VIEW_W-1:0] cmp_view_i,
  output slot_stat_t        stat_o,
  output logic [VIEW_W-1:0] rdata_o
);

  logic [VIEW_W-1:0] view_mem [SLOTS];
  logic [VIEW_W-1:0] rdata_q;
  logic [SLOT_W-1:0] rd_addr_q;
  logic [SLOTS-1:0]  live_q, live_d;
  logic [SLOTS-1:0]  dirty_q, dirty_d;
  logic [SLOTS-1:0]  above;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      view_mem[cmd_i.wr_addr] <= cmd_i.wr_view;
    end
    if (cmd_i.rd_en) begin
      rdata_q   <= view_mem[cmd_i.rd_addr];
      rd_addr_q <= cmd_i.rd_addr;
    end
  end

  always_comb begin
    live_d  = live_q;
    dirty_d = dirty_q;
    if (cmd_i.wr_en) begin
      live_d[cmd_i.wr_addr]  = 1'b1;
      dirty_d[cmd_i.wr_addr] = 1'b1;
    end
    if (cmd_i.clr_en) begin
      live_d[cmd_i.clr_addr]  = 1'b0;
      dirty_d[cmd_i.clr_addr] = 1'b0;
    end
    if (cmd_i.clr_dirty_all) begin
      dirty_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= '0;
      dirty_q <= '0;
    end else begin
      live_q  <= live_d;
      dirty_q <= dirty_d;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      above[i] = SLOT_W'(i) > rd_addr_q;
    end
  end

  assign stat_o.addr       = rd_addr_q;
  assign stat_o.live       = live_q[rd_addr_q];
  assign stat_o.dirty      = dirty_q[rd_addr_q];
  assign stat_o.hit        = live_q[rd_addr_q] && (rdata_q == cmp_view_i);
  assign stat_o.more       = |(live_q & dirty_q & above);
  assign stat_o.probe_live = live_q[cmd_i.probe_addr];
  assign rdata_o           = rdata_q;

endmodule

// File: rtl/dedup_slot_allocator_dirty_commit_unit.sv
// Remove: done in the accept cycle, no result. Refused register: answered, no scan.
// Register: a dedup scan reads the slot memory one entry a cycle; a hit answers with
// the matching slot, a miss pops the free stack or else takes a fresh slot if any.
// Commit: scans the 64 slots, emitting each live dirty one, and stalls on the output.
// One item at a time; the next is taken once the sequencer is back in idle.
// Reset clears control state and the live and dirty bits; no memory clearing pass.
module dedup_slot_allocator_dirty_commit_unit import dsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic [BIND_W-1:0]     binding_i,
  input  logic [VIEW_W-1:0]     view_i,
  input  logic [SIDX_W-1:0]     slot_index_i,
  input  logic                  handle_valid_i,
  input  logic [VIEW_W-1:0]     sampler_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_kind_o,
  output logic                  handle_ok_o,
  output logic [BIND_W-1:0]     out_binding_o,
  output logic [OUT_SLOT_W-1:0] out_slot_o,
  output logic [VIEW_W-1:0]     out_view_o,
  output logic [VIEW_W-1:0]     out_sampler_o,
  output logic                  last_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_ANS    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  logic [2:0]              state_q, state_d;
  logic [BIND_W-1:0]       chan_q;
  logic [MAX_W-1:0]        max_q;
  logic [CNT_W-1:0]        usable;
  logic [CNT_W-1:0]        free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]        fresh_q, fresh_d;
  logic [CNT_W-1:0]        iss_q, iss_d;
  logic [CNT_W-1:0]        fs_top;
  logic                    chk_v_q, chk_v_d;
  logic [BIND_W-1:0]       bind_q, bind_d;
  logic [VIEW_W-1:0]       view_q, view_d;
  logic [VIEW_W-1:0]       samp_q, samp_d;
  logic                    ans_ok_q, ans_ok_d;
  logic [SLOT_W-1:0]       ans_slot_q, ans_slot_d;

  logic [SLOT_W-1:0]       free_mem [SLOTS];
  logic [SLOT_W-1:0]       fs_rdata_q;
  logic                    fs_rd_en, fs_wr_en;

  logic                    out_valid_q, out_valid_d;
  logic                    out_kind_q, out_kind_d;
  logic                    out_ok_q, out_ok_d;
  logic [BIND_W-1:0]       out_bind_q, out_bind_d;
  logic [SLOT_W-1:0]       out_slot_q, out_slot_d;
  logic [VIEW_W-1:0]       out_view_q, out_view_d;
  logic [VIEW_W-1:0]       out_samp_q, out_samp_d;
  logic                    out_last_q, out_last_d;
  logic                    out_free, need_emit;

  slot_cmd_t               cmd;
  slot_stat_t              stat;
  logic [VIEW_W-1:0]       rdata;

  dsa_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmp_view_i (view_q),
    .stat_o     (stat),
    .rdata_o    (rdata)
  );

  assign usable     = (CNT_W'(max_q) > SLOTS_CNT) ? SLOTS_CNT : CNT_W'(max_q);
  assign fs_top     = free_cnt_q - CNT_W'(1);
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign need_emit  = chk_v_q && stat.live && stat.dirty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      max_q  <= MAX_W'(SLOTS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANNEL_BINDING: chan_q <= cfg_data_i[BIND_W-1:0];
        CFG_MAX_SLOTS:       max_q  <= cfg_data_i[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fs_wr_en) begin
      free_mem[free_cnt_q[SLOT_W-1:0]] <= slot_index_i[SLOT_W-1:0];
    end
    if (fs_rd_en) begin
      fs_rdata_q <= free_mem[fs_top[SLOT_W-1:0]];
    end
  end

  always_comb begin
    state_d     = state_q;
    free_cnt_d  = free_cnt_q;
    fresh_d     = fresh_q;
    iss_d       = iss_q;
    chk_v_d     = chk_v_q;
    bind_d      = bind_q;
    view_d      = view_q;
    samp_d      = samp_q;
    ans_ok_d    = ans_ok_q;
    ans_slot_d  = ans_slot_q;
    fs_rd_en    = 1'b0;
    fs_wr_en    = 1'b0;
    cmd         = '0;
    cmd.wr_view = view_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_ok_d    = out_ok_q;
    out_bind_d  = out_bind_q;
    out_slot_d  = out_slot_q;
    out_view_d  = out_view_q;
    out_samp_d  = out_samp_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        cmd.probe_addr = slot_index_i[SLOT_W-1:0];
        if (in_valid_i) begin
          bind_d = binding_i;
          view_d = view_i;
          samp_d = sampler_i;
          iss_d  = '0;
          chk_v_d = 1'b0;
          case (req_type_i)
            REQ_REGISTER: begin
              if (binding_i != chan_q || view_i == '0) begin
                ans_ok_d = 1'b0;
                state_d  = S_ANS;
              end else begin
                state_d = S_SCAN;
              end
            end
            REQ_REMOVE: begin
              if (handle_valid_i && binding_i == chan_q && slot_index_i < usable &&
                  stat.probe_live) begin
                cmd.clr_en   = 1'b1;
                cmd.clr_addr = slot_index_i[SLOT_W-1:0];
                if (free_cnt_q < SLOTS_CNT) begin
                  fs_wr_en   = 1'b1;
                  free_cnt_d = free_cnt_q + CNT_W'(1);
                end
              end
            end
            REQ_COMMIT: state_d = S_COMMIT;
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (chk_v_q && stat.hit) begin
          ans_ok_d   = 1'b1;
          ans_slot_d = stat.addr;
          state_d    = S_ANS;
        end else if (iss_q < SLOTS_CNT) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = iss_q[SLOT_W-1:0];
          iss_d       = iss_q + CNT_W'(1);
          chk_v_d     = 1'b1;
        end else if (chk_v_q) begin
          chk_v_d = 1'b0;
        end else if (free_cnt_q != '0) begin
          fs_rd_en = 1'b1;
          state_d  = S_POP;
        end else if (fresh_q < usable) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = fresh_q[SLOT_W-1:0];
          fresh_d     = fresh_q + CNT_W'(1);
          ans_ok_d    = 1'b1;
          ans_slot_d  = fresh_q[SLOT_W-1:0];
          state_d     = S_ANS;
        end else begin
          ans_ok_d = 1'b0;
          state_d  = S_ANS;
        end
      end

      S_POP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = fs_rdata_q;
        free_cnt_d  = fs_top;
        ans_ok_d    = 1'b1;
        ans_slot_d  = fs_rdata_q;
        state_d     = S_ANS;
      end

      S_ANS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = OUT_ANSWER;
          out_ok_d    = ans_ok_q;
          out_bind_d  = ans_ok_q ? bind_q : '0;
          out_slot_d  = ans_ok_q ? ans_slot_q : '0;
          out_view_d  = ans_ok_q ? view_q : '0;
          out_samp_d  = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_COMMIT: begin
        if (!need_emit || out_free) begin
          if (need_emit) begin
            out_valid_d = 1'b1;
            out_kind_d  = OUT_WRITE;
            out_ok_d    = 1'b0;
            out_bind_d  = chan_q;
            out_slot_d  = stat.addr;
            out_view_d  = rdata;
            out_samp_d  = samp_q;
            out_last_d  = !stat.more;
          end
          if (iss_q < SLOTS_CNT) begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = iss_q[SLOT_W-1:0];
            iss_d       = iss_q + CNT_W'(1);
            chk_v_d     = 1'b1;
          end else if (chk_v_q) begin
            chk_v_d = 1'b0;
          end else begin
            cmd.clr_dirty_all = 1'b1;
            state_d           = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_cnt_q  <= '0;
      fresh_q     <= '0;
      iss_q       <= '0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_cnt_q  <= free_cnt_d;
      fresh_q     <= fresh_d;
      iss_q       <= iss_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bind_q     <= bind_d;
    view_q     <= view_d;
    samp_q     <= samp_d;
    ans_ok_q   <= ans_ok_d;
    ans_slot_q <= ans_slot_d;
    out_kind_q <= out_kind_d;
    out_ok_q   <= out_ok_d;
    out_bind_q <= out_bind_d;
    out_slot_q <= out_slot_d;
    out_view_q <= out_view_d;
    out_samp_q <= out_samp_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign handle_ok_o   = out_ok_q;
  assign out_binding_o = out_bind_q;
  assign out_slot_o    = OUT_SLOT_W'(out_slot_q);
  assign out_view_o    = out_view_q;
  assign out_sampler_o = out_samp_q;
  assign last_o        = out_last_q;

`ifndef ASSERT_OFF
  // every slot on the free stack was once handed out by the bump pointer
  a_free_le_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= fresh_q)
    else $error("free stack deeper than slots ever allocated");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= SLOTS_CNT)
    else $error("bump pointer past slot count");

  a_pop_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> $past(state_q) == S_SCAN && free_cnt_q != '0)
    else $error("free stack pop without a missed scan");

  a_commit_ends_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT && state_d == S_IDLE |-> !chk_v_q && iss_q == SLOTS_CNT)
    else $error("commit left before the scan completed");
`endif

endmodule
